>>> hdl/edmc_pkg.sv
// edmc_pkg: shared constants and types for the encoder distance move controller
// no dependencies
`timescale 1ns / 1ps

package edmc_pkg;

  localparam int TargetW  = 20;
  localparam int ZoneW    = 16;
  localparam int SpeedCfgW = 8;
  localparam int DriveW   = 9;
  localparam int AvgW     = 21;
  localparam int SpeedW   = 10;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  localparam logic [AvgW-1:0]          AvgMax    = {AvgW{1'b1}};
  localparam logic signed [SpeedW-1:0] MinSpeed  = 10'sd60;
  localparam logic signed [SpeedW-1:0] TrimSpeed = 10'sd15;
  localparam int                       TrimDiff  = 5;

  typedef enum logic [CfgIdxW-1:0] {
    RegTargetPulses  = 3'd0,
    RegBackward      = 3'd1,
    RegBaseSpeed     = 3'd2,
    RegSlowSpeed     = 3'd3,
    RegSlowZone      = 3'd4,
    RegUnitPulses    = 3'd5
  } cfg_reg_e;

endpackage

>>> hdl/encoder_distance_move_controller.sv
// encoder_distance_move_controller: quadrature decode, averaged distance and speed profile
// depends on edmc_pkg
//
//   channel | signals                                   | direction
//   in      | in_valid_i, in_stall_o, start/encoder pins | sample transaction in
//   out     | out_valid_o, out_stall_i, drives/done/avg  | result transaction out
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i/data | register write
//
// one sample per cycle while the output is not stalled; a sample passes the input register, then the result register
// encoder counts and move state update when a sample passes into the result register
// a stalled output holds both stages; the input register still fills while a result waits
// reset clears counts, levels, move state and loads register defaults; cfg is always ready
`timescale 1ns / 1ps

module encoder_distance_move_controller #(
  parameter int COUNT_WIDTH = 22
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic                                       start_req_i,
  input  logic                                       left_a_i,
  input  logic                                       left_b_i,
  input  logic                                       right_a_i,
  input  logic                                       right_b_i,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic signed [edmc_pkg::DriveW-1:0]         left_drive_o,
  output logic signed [edmc_pkg::DriveW-1:0]         right_drive_o,
  output logic                                       done_res_o,
  output logic [edmc_pkg::AvgW-1:0]                  average_count_o,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [edmc_pkg::CfgIdxW-1:0]               cfg_index_i,
  input  logic [edmc_pkg::CfgDataW-1:0]              cfg_data_i
);
  import edmc_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int WW = (CW > 22) ? CW : 22;
  localparam logic signed [CW-1:0] CountLim = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW:0]   DiffHi   = (CW+1)'(TrimDiff);
  localparam logic signed [CW:0]   DiffLo   = -DiffHi;

  // configuration registers
  logic [TargetW-1:0]   target_q;
  logic                 backward_q;
  logic [SpeedCfgW-1:0] base_q;
  logic [SpeedCfgW-1:0] slow_q;
  logic [ZoneW-1:0]     zone_q;
  logic [ZoneW-1:0]     unit_q;

  // input stage
  logic s1_valid_q, s1_start_q, s1_la_q, s1_lb_q, s1_ra_q, s1_rb_q;

  // move state
  logic signed [CW-1:0] left_cnt_q, left_cnt_d;
  logic signed [CW-1:0] right_cnt_q, right_cnt_d;
  logic                 last_l_q, last_l_d, last_r_q, last_r_d;
  logic                 moving_q, moving_d;

  // result stage
  logic                     out_valid_q;
  logic signed [DriveW-1:0] ldrive_q, ldrive_d, rdrive_q, rdrive_d;
  logic                     done_q, done_d;
  logic [AvgW-1:0]          avg_q, avg_d;

  logic out_adv, s1_fire, in_take;

  logic                      mov_eff, last_l_eff, last_r_eff;
  logic signed [CW-1:0]      lc_eff, rc_eff;
  logic [CW-1:0]             labs, rabs;
  logic [CW:0]               abs_sum;
  logic [WW-1:0]             avg_w;
  logic signed [WW:0]        rem, zone_s, unit_s;
  logic signed [CW:0]        diff;
  logic signed [SpeedW-1:0]  slow_s, half_src, half, mid, speed, ls, rs;

  function automatic logic signed [CW-1:0] bump(logic signed [CW-1:0] c, logic up);
    logic signed [CW-1:0] r;
    if (up) begin
      r = (c < CountLim) ? c + CW'(1) : CountLim;
    end else begin
      r = (c > -CountLim) ? c - CW'(1) : -CountLim;
    end
    return r;
  endfunction

  function automatic logic signed [SpeedW-1:0] clamp_slow(logic signed [SpeedW-1:0] x,
                                                          logic signed [SpeedW-1:0] hi);
    logic signed [SpeedW-1:0] r;
    if (x < MinSpeed) begin
      r = MinSpeed;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

  assign out_adv     = !out_valid_q || !out_stall_i;
  assign s1_fire     = s1_valid_q && out_adv;
  assign in_stall_o  = s1_valid_q && !out_adv;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mov_eff    = moving_q;
    lc_eff     = left_cnt_q;
    rc_eff     = right_cnt_q;
    last_l_eff = last_l_q;
    last_r_eff = last_r_q;
    if (s1_start_q) begin
      mov_eff    = 1'b1;
      lc_eff     = '0;
      rc_eff     = '0;
      last_l_eff = s1_la_q;
      last_r_eff = s1_ra_q;
    end
    left_cnt_d  = lc_eff;
    right_cnt_d = rc_eff;
    last_l_d    = last_l_eff;
    last_r_d    = last_r_eff;
    if (mov_eff && (s1_la_q != last_l_eff)) begin
      left_cnt_d = bump(lc_eff, s1_la_q != s1_lb_q);
      last_l_d   = s1_la_q;
    end
    if (mov_eff && (s1_ra_q != last_r_eff)) begin
      right_cnt_d = bump(rc_eff, s1_ra_q != s1_rb_q);
      last_r_d    = s1_ra_q;
    end

    labs    = left_cnt_d[CW-1]  ? CW'(-left_cnt_d)  : CW'(left_cnt_d);
    rabs    = right_cnt_d[CW-1] ? CW'(-right_cnt_d) : CW'(right_cnt_d);
    abs_sum = {1'b0, labs} + {1'b0, rabs};
    avg_w   = WW'(abs_sum[CW:1]);
    avg_d   = (avg_w > WW'(AvgMax)) ? AvgMax : avg_w[AvgW-1:0];

    rem    = $signed({1'b0, WW'(target_q)}) - $signed({1'b0, avg_w});
    zone_s = $signed({1'b0, WW'(zone_q)});
    unit_s = $signed({1'b0, WW'(unit_q)});

    slow_s   = $signed({2'b00, slow_q});
    half_src = slow_s - MinSpeed;
    half     = (half_src + (half_src[SpeedW-1] ? SpeedW'(1) : SpeedW'(0))) >>> 1;
    mid      = MinSpeed + half;

    if (rem > zone_s) begin
      speed = $signed({2'b00, base_q});
    end else if (rem == zone_s) begin
      speed = clamp_slow(slow_s, slow_s);
    end else if (rem >= unit_s) begin
      speed = clamp_slow(mid, slow_s);
    end else begin
      speed = clamp_slow(MinSpeed, slow_s);
    end

    diff = $signed({1'b0, labs}) - $signed({1'b0, rabs});
    ls   = speed - ((diff > DiffHi) ? TrimSpeed : SpeedW'(0));
    rs   = speed - ((diff < DiffLo) ? TrimSpeed : SpeedW'(0));

    moving_d = mov_eff;
    done_d   = 1'b0;
    ldrive_d = '0;
    rdrive_d = '0;
    if (mov_eff) begin
      if (avg_w >= WW'(target_q)) begin
        done_d   = 1'b1;
        moving_d = 1'b0;
      end else if (backward_q) begin
        ldrive_d = DriveW'(-ls);
        rdrive_d = DriveW'(-rs);
      end else begin
        ldrive_d = DriveW'(ls);
        rdrive_d = DriveW'(rs);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      backward_q <= 1'b0;
      base_q     <= SpeedCfgW'(150);
      slow_q     <= SpeedCfgW'(100);
      zone_q     <= ZoneW'(81);
      unit_q     <= ZoneW'(40);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        RegTargetPulses: target_q   <= cfg_data_i[TargetW-1:0];
        RegBackward:     backward_q <= cfg_data_i[0];
        RegBaseSpeed:    base_q     <= cfg_data_i[SpeedCfgW-1:0];
        RegSlowSpeed:    slow_q     <= cfg_data_i[SpeedCfgW-1:0];
        RegSlowZone:     zone_q     <= cfg_data_i[ZoneW-1:0];
        RegUnitPulses:   unit_q     <= cfg_data_i[ZoneW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (out_adv || !s1_valid_q) begin
      s1_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_start_q <= start_req_i;
      s1_la_q    <= left_a_i;
      s1_lb_q    <= left_b_i;
      s1_ra_q    <= right_a_i;
      s1_rb_q    <= right_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cnt_q  <= '0;
      right_cnt_q <= '0;
      last_l_q    <= 1'b0;
      last_r_q    <= 1'b0;
      moving_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        left_cnt_q  <= left_cnt_d;
        right_cnt_q <= right_cnt_d;
        last_l_q    <= last_l_d;
        last_r_q    <= last_r_d;
        moving_q    <= moving_d;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      ldrive_q <= ldrive_d;
      rdrive_q <= rdrive_d;
      done_q   <= done_d;
      avg_q    <= avg_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_drive_o    = ldrive_q;
  assign right_drive_o   = rdrive_q;
  assign done_res_o      = done_q;
  assign average_count_o = avg_q;

  // a finished move shows stopped drives and leaves the block idle
  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> left_drive_o == '0 && right_drive_o == '0 && !moving_q)
    else $error("done result with drive or move still active");

  // a non-zero drive is only shown while a move is in progress
  a_drive_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (left_drive_o != '0 || right_drive_o != '0) |-> moving_q)
    else $error("drive shown while idle");

  // saturation keeps counts off the most negative code
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_cnt_q != -CountLim - CW'(1) && right_cnt_q != -CountLim - CW'(1))
    else $error("count beyond saturation limit");

  // an empty input register never stalls the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  // counts change only when a sample passes to the result register
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(left_cnt_q) && $stable(right_cnt_q))
    else $error("count changed without a sample");

endmodule

>>> tb/sv/edmc_move_checker.sv
// edmc_move_checker: watches the sample, result and register channels of the move controller,
// predicts every result from its own copy of counts and registers, and compares in order
// depends on edmc_pkg
`timescale 1ns / 1ps

module edmc_move_checker #(
  parameter int COUNT_WIDTH = 22
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         start_req_i,
  input  logic                         left_a_i,
  input  logic                         left_b_i,
  input  logic                         right_a_i,
  input  logic                         right_b_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [edmc_pkg::DriveW-1:0]  left_drive_i,
  input  logic [edmc_pkg::DriveW-1:0]  right_drive_i,
  input  logic                         done_res_i,
  input  logic [edmc_pkg::AvgW-1:0]    average_count_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [edmc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [edmc_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           mismatches_o,
  output int                           pending_o
);

  import edmc_pkg::*;

  typedef struct packed {
    logic [DriveW-1:0] left_drive;
    logic [DriveW-1:0] right_drive;
    logic              done;
    logic [AvgW-1:0]   avg;
  } move_result_t;

  move_result_t expected_drive_q[$];

  longint left_cnt;
  longint right_cnt;
  bit     left_lvl;
  bit     right_lvl;
  bit     in_move;

  int target_p;
  bit go_back;
  int base_spd;
  int slow_spd;
  int zone_p;
  int unit_p;
  int errs;

  function automatic longint step_count(longint c, bit up);
    longint lim;
    lim = (longint'(1) << (COUNT_WIDTH - 1)) - 1;
    if (up) return (c < lim) ? c + 1 : lim;
    return (c > -lim) ? c - 1 : -lim;
  endfunction

  function automatic longint clamp_to_slow(longint x);
    if (x < longint'(MinSpeed)) return longint'(MinSpeed);
    if (x > slow_spd) return slow_spd;
    return x;
  endfunction

  function automatic move_result_t predict_sample(bit start, bit la, bit lb, bit ra, bit rb);
    move_result_t r;
    longint labs, rabs, avg, rem, spd, ls, rs, dl, dr;
    if (start) begin
      left_cnt  = 0;
      right_cnt = 0;
      left_lvl  = la;
      right_lvl = ra;
      in_move   = 1'b1;
    end
    if (in_move) begin
      if (la != left_lvl) begin
        left_cnt = step_count(left_cnt, la != lb);
        left_lvl = la;
      end
      if (ra != right_lvl) begin
        right_cnt = step_count(right_cnt, ra != rb);
        right_lvl = ra;
      end
    end
    labs = (left_cnt < 0) ? -left_cnt : left_cnt;
    rabs = (right_cnt < 0) ? -right_cnt : right_cnt;
    avg  = (labs + rabs) / 2;
    dl = 0;
    dr = 0;
    r.done = 1'b0;
    if (in_move) begin
      rem = longint'(target_p) - avg;
      if (rem > zone_p) spd = base_spd;
      else if (rem == zone_p) spd = clamp_to_slow(slow_spd);
      else if (rem >= unit_p) spd = clamp_to_slow(MinSpeed + (slow_spd - MinSpeed) / 2);
      else spd = clamp_to_slow(MinSpeed);
      ls = spd;
      rs = spd;
      if (labs - rabs > TrimDiff) ls = spd - TrimSpeed;
      if (labs - rabs < -TrimDiff) rs = spd - TrimSpeed;
      if (avg >= target_p) begin
        r.done  = 1'b1;
        in_move = 1'b0;
      end else if (go_back) begin
        dl = -ls;
        dr = -rs;
      end else begin
        dl = ls;
        dr = rs;
      end
    end
    r.left_drive  = dl[DriveW-1:0];
    r.right_drive = dr[DriveW-1:0];
    r.avg         = (avg > longint'(AvgMax)) ? AvgMax : avg[AvgW-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want_v,
                             logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    move_result_t got;
    move_result_t want;
    if (!rst_ni) begin
      expected_drive_q.delete();
      left_cnt     = 0;
      right_cnt    = 0;
      left_lvl     = 1'b0;
      right_lvl    = 1'b0;
      in_move      = 1'b0;
      target_p     = 0;
      go_back      = 1'b0;
      base_spd     = 150;
      slow_spd     = 100;
      zone_p       = 81;
      unit_p       = 40;
      errs         = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{left_drive_i, right_drive_i, done_res_i, average_count_i};
        if (expected_drive_q.size() == 0) begin
          $display("%0t: result transaction with none expected", $time);
          errs++;
        end else begin
          want = expected_drive_q.pop_front();
          check_field("left_drive", 32'($signed(want.left_drive)),
                      32'($signed(got.left_drive)));
          check_field("right_drive", 32'($signed(want.right_drive)),
                      32'($signed(got.right_drive)));
          check_field("done_res", 32'(want.done), 32'(got.done));
          check_field("average_count", 32'(want.avg), 32'(got.avg));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_drive_q.push_back(predict_sample(start_req_i, left_a_i, left_b_i,
                                                  right_a_i, right_b_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegTargetPulses: target_p = int'(cfg_data_i[TargetW-1:0]);
          RegBackward:     go_back  = cfg_data_i[0];
          RegBaseSpeed:    base_spd = int'(cfg_data_i[SpeedCfgW-1:0]);
          RegSlowSpeed:    slow_spd = int'(cfg_data_i[SpeedCfgW-1:0]);
          RegSlowZone:     zone_p   = int'(cfg_data_i[ZoneW-1:0]);
          RegUnitPulses:   unit_p   = int'(cfg_data_i[ZoneW-1:0]);
          default: ;
        endcase
      end
      mismatches_o <= errs;
      pending_o    <= expected_drive_q.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// tb_top: drives quadrature encoder moves and register settings into the move controller
// under varying idle and stall patterns, and reports the verdict of edmc_move_checker
// depends on edmc_pkg, encoder_distance_move_controller and edmc_move_checker
`timescale 1ns / 1ps

module tb_top;

  import edmc_pkg::*;

  localparam int CountW     = 22;
  localparam int PhaseCount = 12;
  localparam int PhaseItems = 95;
  localparam int QuietLimit = 2000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        start_req_i;
  logic                        left_a_i;
  logic                        left_b_i;
  logic                        right_a_i;
  logic                        right_b_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [DriveW-1:0]    left_drive_o;
  logic signed [DriveW-1:0]    right_drive_o;
  logic                        done_res_o;
  logic [AvgW-1:0]             average_count_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [CfgIdxW-1:0]          cfg_index_i;
  logic [CfgDataW-1:0]         cfg_data_i;

  int mismatches;
  int pending;
  int sx_pct = 30;
  int rx_pct = 48;
  bit long_hold = 1'b0;
  int n_sent = 0;
  int lph = 0;
  int rph = 0;
  int quiet_cycles = 0;

  encoder_distance_move_controller #(.COUNT_WIDTH(CountW)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .start_req_i,
    .left_a_i, .left_b_i, .right_a_i, .right_b_i,
    .out_valid_o, .out_stall_i, .left_drive_o, .right_drive_o, .done_res_o,
    .average_count_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  edmc_move_checker #(.COUNT_WIDTH(CountW)) u_move_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .start_req_i,
    .left_a_i, .left_b_i, .right_a_i, .right_b_i,
    .out_valid_i(out_valid_o), .out_stall_i, .left_drive_i(left_drive_o),
    .right_drive_i(right_drive_o), .done_res_i(done_res_o),
    .average_count_i(average_count_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit enc_a(int p);
    return p == 1 || p == 2;
  endfunction

  function automatic bit enc_b(int p);
    return p >= 2;
  endfunction

  function automatic int step_wheel(int p, int fwd_pct);
    int x;
    x = $urandom_range(99);
    if (x < fwd_pct) return (p + 1) % 4;
    if (x < fwd_pct + 5) return (p + 3) % 4;
    return p;
  endfunction

  task automatic send_sample(bit start, bit la, bit lb, bit ra, bit rb);
    while (sx_pct != 0 && $urandom_range(99) < sx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    start_req_i <= start;
    left_a_i    <= la;
    left_b_i    <= lb;
    right_a_i   <= ra;
    right_b_i   <= rb;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
  endtask

  task automatic send_wheels(bit start);
    send_sample(start, enc_a(lph), enc_b(lph), enc_a(rph), enc_b(rph));
  endtask

  // no transaction in flight before a register write
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(int target, int bwd, int base, int slow, int zone, int unit);
    cfg_reg_e            idx[6];
    logic [CfgDataW-1:0] val[6];
    idx = '{RegTargetPulses, RegBackward, RegBaseSpeed, RegSlowSpeed, RegSlowZone,
            RegUnitPulses};
    val = '{CfgDataW'(target), CfgDataW'(bwd), CfgDataW'(base), CfgDataW'(slow),
            CfgDataW'(zone), CfgDataW'(unit)};
    for (int k = 0; k < 6; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic pick_settings(int ph);
    case (ph)
      0: apply_settings(25, 0, 0, 0, 0, 0);
      1, 6: apply_settings(1048575, 1, 255, 255, 65535, 65535);
      2: apply_settings(0, $urandom_range(1), $urandom_range(255), $urandom_range(255),
                        $urandom_range(30), $urandom_range(20));
      default: apply_settings($urandom_range(50, 3), $urandom_range(1), $urandom_range(255),
                              $urandom_range(255), $urandom_range(30), $urandom_range(20));
    endcase
  endtask

  // one start, then mostly clean quadrature steps with some noise and restarts
  task automatic run_move(int len);
    int lf;
    int rf;
    int r;
    lf = $urandom_range(95, 30);
    rf = $urandom_range(95, 30);
    if ($urandom_range(3) == 0) rf = 0;
    send_wheels(1'b1);
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 6) begin
        send_sample(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (r < 8) begin
        send_wheels(1'b1);
      end else begin
        lph = step_wheel(lph, lf);
        rph = step_wheel(rph, rf);
        send_wheels(1'b0);
      end
    end
  endtask

  initial begin : receiver
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (64) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int  phase_start;
    int  len;
    bit  held;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    start_req_i <= 1'b0;
    left_a_i    <= 1'b0;
    left_b_i    <= 1'b0;
    right_a_i   <= 1'b0;
    right_b_i   <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= RegTargetPulses;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero target after reset gives done on the start sample, then an idle sample
    send_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    wait_idle();

    // backward move with a tiny base speed: left runs ahead and its speed is trimmed
    apply_settings(5, 1, 5, 255, 3, 1);
    lph = 0;
    rph = 0;
    send_wheels(1'b1);
    repeat (2) begin
      lph = (lph + 1) % 4;
      send_wheels(1'b0);
    end
    send_wheels(1'b1);
    repeat (14) begin
      lph = (lph + 1) % 4;
      send_wheels(1'b0);
    end
    repeat (6) begin
      rph = (rph + 3) % 4;
      send_wheels(1'b0);
    end
    wait_idle();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph == 4) begin
        sx_pct = 48;
        rx_pct = 30;
      end
      if (ph == 8) begin
        sx_pct = 0;
        rx_pct = 0;
      end
      pick_settings(ph);
      phase_start = n_sent;
      held = 1'b0;
      while (n_sent - phase_start < PhaseItems) begin
        len = $urandom_range(140, 10);
        if (len > PhaseItems - (n_sent - phase_start)) len = PhaseItems - (n_sent - phase_start);
        if (ph % 4 == 1 && !held && n_sent - phase_start > 30) begin
          long_hold = 1'b1;
          held = 1'b1;
        end
        run_move(len);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> encoder_distance_move_controller.f
hdl/edmc_pkg.sv
hdl/encoder_distance_move_controller.sv
tb/sv/edmc_move_checker.sv
tb/sv/tb_top.sv
